// ===== src/complex_arithmetic_unit_macros.svh =====
// Assertion macros for the complex arithmetic unit.
// Taken in by the top level; depends on nothing else.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/cau_pkg.sv =====
// Shared types and constants of the complex arithmetic unit.
// Used by complex_arithmetic_unit and its testbench; depends on nothing else.
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int WIDE_BITS = 2 * WORD_BITS;
  localparam int ROOT_REM_BITS = WORD_BITS + 2;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_NEG  = 4'd4,
    OP_PASS = 4'd5,
    OP_EQ   = 4'd6,
    OP_NE   = 4'd7,
    OP_MAG  = 4'd8
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Result of the ops that finish early; carried down the pipeline.
  typedef struct packed {
    word_t      re;
    word_t      im;
    logic       cmp;
    logic [1:0] status;
  } res_t;

  // One stage of the shared divide and square root column.
  typedef struct packed {
    logic                     v;
    logic [3:0]               op;
    res_t                     base;
    logic                     dz;
    logic                     neg_re;
    logic                     neg_im;
    logic                     ovf_re;
    logic                     ovf_im;
    logic [WIDE_BITS-1:0]     d;
    logic [WIDE_BITS-1:0]     r_re;
    logic [WIDE_BITS-1:0]     r_im;
    logic [WORD_BITS-1:0]     n_re;
    logic [WORD_BITS-1:0]     n_im;
    logic [WORD_BITS-1:0]     q_re;
    logic [WORD_BITS-1:0]     q_im;
    logic [WIDE_BITS-1:0]     rad;
    logic [ROOT_REM_BITS-1:0] rem;
    logic [WORD_BITS-1:0]     root;
  } iter_t;

endpackage

// ===== src/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: a fully pipelined Q16.16 complex ALU.
// Depends on cau_pkg and complex_arithmetic_unit_macros.svh.

// Takes one item per cycle unless a held result is stalled at the output.
// The first four stages register the operands, form the products, the sums and
// the divisor; the next 33 stages are a column whose head takes the first partial
// remainders and whose other stages each produce one quotient bit of both divide
// components and one root bit of the magnitude; the last stage saturates and holds
// the output. A stall at the output while out_valid is high freezes the whole
// pipeline and is passed straight back as in_stall, so nothing is lost or repeated.
module complex_arithmetic_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [3:0]            op,
  input  cau_pkg::word_t        a_re,
  input  cau_pkg::word_t        a_im,
  input  cau_pkg::word_t        b_re,
  input  cau_pkg::word_t        b_im,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cau_pkg::word_t        res_re,
  output cau_pkg::word_t        res_im,
  output logic                  cmp_true,
  output logic [1:0]            status
);
  import cau_pkg::*;

  localparam int STEPS = WORD_BITS;
  localparam int INT_BITS = WORD_BITS - FRAC_BITS;
  localparam int SUM_BITS = WIDE_BITS + 1;
  localparam int MUL_BITS = WIDE_BITS + 2;
  localparam int FLR_BITS = MUL_BITS - FRAC_BITS;
  localparam int CLP_BITS = FLR_BITS;
  localparam int CMP_BITS = WIDE_BITS + INT_BITS;

  // Clamp to the word range; the top bit of the result flags saturation.
  function automatic logic [WORD_BITS:0] sat_word(input logic signed [CLP_BITS-1:0] x);
    logic [WORD_BITS:0] r;
    if (x > CLP_BITS'(WORD_MAX)) begin
      r = {1'b1, WORD_MAX};
    end else if (x < CLP_BITS'(WORD_MIN)) begin
      r = {1'b1, WORD_MIN};
    end else begin
      r = {1'b0, x[WORD_BITS-1:0]};
    end
    return r;
  endfunction

  // Sign and saturate one divide component (quotient truncated toward zero).
  function automatic logic [WORD_BITS:0] div_fix(input logic neg, input logic ovf,
                                                 input logic [WORD_BITS-1:0] q);
    logic [WORD_BITS:0] r;
    if (!neg) begin
      if (ovf || q[WORD_BITS-1]) begin
        r = {1'b1, WORD_MAX};
      end else begin
        r = {1'b0, q};
      end
    end else begin
      if (ovf || (q > WORD_MIN)) begin
        r = {1'b1, WORD_MIN};
      end else begin
        r = {1'b0, -q};
      end
    end
    return r;
  endfunction

  // One restoring step of both dividers and of the square root.
  function automatic iter_t iter_step(input iter_t c);
    iter_t                    n;
    logic [WIDE_BITS:0]       tr;
    logic [WIDE_BITS:0]       ti;
    logic [ROOT_REM_BITS+1:0] sr;
    logic [ROOT_REM_BITS+1:0] st;
    n  = c;
    tr = {c.r_re, c.n_re[WORD_BITS-1]};
    ti = {c.r_im, c.n_im[WORD_BITS-1]};
    if (tr >= {1'b0, c.d}) begin
      n.r_re = WIDE_BITS'(tr - {1'b0, c.d});
      n.q_re = {c.q_re[WORD_BITS-2:0], 1'b1};
    end else begin
      n.r_re = tr[WIDE_BITS-1:0];
      n.q_re = {c.q_re[WORD_BITS-2:0], 1'b0};
    end
    if (ti >= {1'b0, c.d}) begin
      n.r_im = WIDE_BITS'(ti - {1'b0, c.d});
      n.q_im = {c.q_im[WORD_BITS-2:0], 1'b1};
    end else begin
      n.r_im = ti[WIDE_BITS-1:0];
      n.q_im = {c.q_im[WORD_BITS-2:0], 1'b0};
    end
    n.n_re = {c.n_re[WORD_BITS-2:0], 1'b0};
    n.n_im = {c.n_im[WORD_BITS-2:0], 1'b0};
    sr = {c.rem, c.rad[WIDE_BITS-1:WIDE_BITS-2]};
    st = {2'b00, c.root, 2'b01};
    if (sr >= st) begin
      n.rem  = ROOT_REM_BITS'(sr - st);
      n.root = {c.root[WORD_BITS-2:0], 1'b1};
    end else begin
      n.rem  = sr[ROOT_REM_BITS-1:0];
      n.root = {c.root[WORD_BITS-2:0], 1'b0};
    end
    n.rad = {c.rad[WIDE_BITS-3:0], 2'b00};
    return n;
  endfunction

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 0: operand registers.
  logic       v0;
  logic [3:0] op0;
  word_t      ar0, ai0, br0, bi0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      op0 <= op;
      ar0 <= a_re;
      ai0 <= a_im;
      br0 <= b_re;
      bi0 <= b_im;
    end
  end

  // Stage 1: products, and the add, subtract, negate, pass and compare results.
  logic                        v1;
  logic [3:0]                  op1;
  logic signed [WIDE_BITS-1:0] pr_rr, pr_ii, pr_ri, pr_ir, sq_x, sq_y;
  res_t                        base1, base1_next;
  word_t                       mx, my;
  logic [WORD_BITS:0]          cr, ci;

  assign mx = (op0 == OP_MAG) ? ar0 : br0;
  assign my = (op0 == OP_MAG) ? ai0 : bi0;

  always_comb begin
    base1_next = '0;
    cr = '0;
    ci = '0;
    case (op0)
      OP_ADD: begin
        cr = sat_word(CLP_BITS'((WORD_BITS + 1)'(ar0) + (WORD_BITS + 1)'(br0)));
        ci = sat_word(CLP_BITS'((WORD_BITS + 1)'(ai0) + (WORD_BITS + 1)'(bi0)));
      end
      OP_SUB: begin
        cr = sat_word(CLP_BITS'((WORD_BITS + 1)'(ar0) - (WORD_BITS + 1)'(br0)));
        ci = sat_word(CLP_BITS'((WORD_BITS + 1)'(ai0) - (WORD_BITS + 1)'(bi0)));
      end
      OP_NEG: begin
        cr = sat_word(CLP_BITS'(-((WORD_BITS + 1)'(ar0))));
        ci = sat_word(CLP_BITS'(-((WORD_BITS + 1)'(ai0))));
      end
      OP_PASS: begin
        cr = {1'b0, ar0};
        ci = {1'b0, ai0};
      end
      OP_EQ:   base1_next.cmp = (ar0 == br0) && (ai0 == bi0);
      OP_NE:   base1_next.cmp = (ar0 != br0) || (ai0 != bi0);
      default: base1_next.cmp = 1'b0;
    endcase
    base1_next.re     = cr[WORD_BITS-1:0];
    base1_next.im     = ci[WORD_BITS-1:0];
    base1_next.status = (cr[WORD_BITS] || ci[WORD_BITS]) ? ST_SAT : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      op1   <= op0;
      base1 <= base1_next;
      pr_rr <= WIDE_BITS'(ar0) * WIDE_BITS'(br0);
      pr_ii <= WIDE_BITS'(ai0) * WIDE_BITS'(bi0);
      pr_ri <= WIDE_BITS'(ar0) * WIDE_BITS'(bi0);
      pr_ir <= WIDE_BITS'(ai0) * WIDE_BITS'(br0);
      sq_x  <= WIDE_BITS'(mx) * WIDE_BITS'(mx);
      sq_y  <= WIDE_BITS'(my) * WIDE_BITS'(my);
    end
  end

  // Stage 2: product sums, divide numerators and the divisor or radicand.
  logic                        v2;
  logic [3:0]                  op2;
  res_t                        base2;
  logic signed [FLR_BITS-1:0]  mre2, mim2;
  logic signed [SUM_BITS-1:0]  nre2, nim2;
  logic [WIDE_BITS-1:0]        d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      op2   <= op1;
      base2 <= base1;
      mre2  <= FLR_BITS'((MUL_BITS'(pr_rr) - MUL_BITS'(pr_ii)) >>> FRAC_BITS);
      mim2  <= FLR_BITS'((MUL_BITS'(pr_ri) + MUL_BITS'(pr_ir)) >>> FRAC_BITS);
      nre2  <= SUM_BITS'(pr_rr) + SUM_BITS'(pr_ii);
      nim2  <= SUM_BITS'(pr_ir) - SUM_BITS'(pr_ri);
      d2    <= $unsigned(sq_x) + $unsigned(sq_y);
    end
  end

  // Stage 3: multiply saturation, numerator magnitudes.
  logic                 v3;
  logic [3:0]           op3;
  res_t                 base3, base3_next;
  logic                 neg_re3, neg_im3, dz3;
  logic [WIDE_BITS-1:0] mag_re3, mag_im3, d3;
  logic [WORD_BITS:0]   mr, mi;

  always_comb begin
    base3_next = base2;
    mr = sat_word(CLP_BITS'(mre2));
    mi = sat_word(CLP_BITS'(mim2));
    if (op2 == OP_MUL) begin
      base3_next.re     = mr[WORD_BITS-1:0];
      base3_next.im     = mi[WORD_BITS-1:0];
      base3_next.status = (mr[WORD_BITS] || mi[WORD_BITS]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      op3     <= op2;
      base3   <= base3_next;
      neg_re3 <= nre2[SUM_BITS-1];
      neg_im3 <= nim2[SUM_BITS-1];
      mag_re3 <= nre2[SUM_BITS-1] ? WIDE_BITS'(-nre2) : nre2[WIDE_BITS-1:0];
      mag_im3 <= nim2[SUM_BITS-1] ? WIDE_BITS'(-nim2) : nim2[WIDE_BITS-1:0];
      d3      <= d2;
      dz3     <= (d2 == '0);
    end
  end

  // Column head: overflow check and the first partial remainders.
  iter_t it [0:STEPS];
  iter_t head;

  always_comb begin
    head        = '0;
    head.v      = v3;
    head.op     = op3;
    head.base   = base3;
    head.dz     = dz3;
    head.neg_re = neg_re3;
    head.neg_im = neg_im3;
    // A quotient of 2^WORD_BITS or more saturates whatever its sign.
    head.ovf_re = CMP_BITS'(mag_re3) >= {d3, {INT_BITS{1'b0}}};
    head.ovf_im = CMP_BITS'(mag_im3) >= {d3, {INT_BITS{1'b0}}};
    head.d      = d3;
    head.r_re   = mag_re3 >> INT_BITS;
    head.r_im   = mag_im3 >> INT_BITS;
    head.n_re   = {mag_re3[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
    head.n_im   = {mag_im3[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
    head.rad    = d3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      it[0].v <= 1'b0;
    end else if (en) begin
      it[0] <= head;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_col
    always_ff @(posedge clk) begin
      if (rst) begin
        it[k].v <= 1'b0;
      end else if (en) begin
        it[k] <= iter_step(it[k-1]);
      end
    end
  end

  // Output stage.
  iter_t              tail;
  res_t               fin;
  logic [WORD_BITS:0] fr, fi;

  assign tail = it[STEPS];

  always_comb begin
    fin = tail.base;
    fr  = div_fix(tail.neg_re, tail.ovf_re, tail.q_re);
    fi  = div_fix(tail.neg_im, tail.ovf_im, tail.q_im);
    case (tail.op)
      OP_DIV: begin
        if (tail.dz) begin
          fin = '0;
          fin.status = ST_DIV0;
        end else begin
          fin.re     = fr[WORD_BITS-1:0];
          fin.im     = fi[WORD_BITS-1:0];
          fin.cmp    = 1'b0;
          fin.status = (fr[WORD_BITS] || fi[WORD_BITS]) ? ST_SAT : ST_OK;
        end
      end
      OP_MAG: begin
        fin.cmp = 1'b0;
        fin.im  = '0;
        if (tail.root[WORD_BITS-1]) begin
          fin.re     = WORD_MAX;
          fin.status = ST_SAT;
        end else begin
          fin.re     = tail.root;
          fin.status = ST_OK;
        end
      end
      default: fin = tail.base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tail.v;
    end
    if (en) begin
      res_re   <= fin.re;
      res_im   <= fin.im;
      cmp_true <= fin.cmp;
      status   <= fin.status;
    end
  end

`include "complex_arithmetic_unit_macros.svh"

  `CAU_ASSERT_SAME(a_div0_zero, clk, rst, out_valid && (status == ST_DIV0), (res_re == '0) && (res_im == '0) && !cmp_true, "divide by zero result is not zero")
  `CAU_ASSERT_SAME(a_cmp_ok, clk, rst, out_valid && cmp_true, (status == ST_OK) && (res_re == '0) && (res_im == '0), "compare result carries data or status")
  `CAU_ASSERT_SAME(a_sat_limit, clk, rst, out_valid && (status == ST_SAT), (res_re == WORD_MAX) || (res_re == WORD_MIN) || (res_im == WORD_MAX) || (res_im == WORD_MIN), "saturated result holds no limit")

endmodule

// ===== tb/complex_arithmetic_unit_tb.sv =====
// Self-checking testbench for the pipelined Q16.16 complex arithmetic unit.
// Depends on cau_pkg and complex_arithmetic_unit; drives items through a
// random-gapped driver and checks results against an in-bench predictor.
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  typedef logic signed [131:0] wide_t;

  typedef struct {
    logic [3:0] op;
    word_t      a_re;
    word_t      a_im;
    word_t      b_re;
    word_t      b_im;
    bit         drain;
  } operands_t;

  typedef struct {
    word_t      re;
    word_t      im;
    logic       cmp;
    logic [1:0] status;
  } alu_result_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] op;
  word_t      a_re, a_im, b_re, b_im;
  logic       out_valid;
  logic       out_stall;
  word_t      res_re, res_im;
  logic       cmp_true;
  logic [1:0] status;

  operands_t   pending_items[$];
  alu_result_t expected_results[$];
  int          gap_left;
  int          stall_left;
  int          items_sent;
  int          results_seen;
  int          errors;
  int          op_count[16];

  complex_arithmetic_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_re(res_re), .res_im(res_im), .cmp_true(cmp_true), .status(status)
  );

  function automatic word_t clamp_word(input wide_t v, inout bit sat);
    if (v > wide_t'(WORD_MAX)) begin
      sat = 1'b1;
      return WORD_MAX;
    end
    if (v < wide_t'(WORD_MIN)) begin
      sat = 1'b1;
      return WORD_MIN;
    end
    return word_t'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Quotient of num * 2^FRAC_BITS by den, truncated toward zero.
  function automatic wide_t scaled_quotient(input wide_t num, input wide_t den);
    wide_t mag;
    mag = (num < 0) ? -num : num;
    mag = (mag <<< FRAC_BITS) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic alu_result_t compute_result(input operands_t it);
    alu_result_t r;
    wide_t ar, ai, br, bi, den;
    bit sat;
    ar = wide_t'(it.a_re);
    ai = wide_t'(it.a_im);
    br = wide_t'(it.b_re);
    bi = wide_t'(it.b_im);
    r = '{re: '0, im: '0, cmp: 1'b0, status: ST_OK};
    sat = 1'b0;
    case (it.op)
      OP_ADD: begin
        r.re = clamp_word(ar + br, sat);
        r.im = clamp_word(ai + bi, sat);
      end
      OP_SUB: begin
        r.re = clamp_word(ar - br, sat);
        r.im = clamp_word(ai - bi, sat);
      end
      OP_MUL: begin
        r.re = clamp_word((ar * br - ai * bi) >>> FRAC_BITS, sat);
        r.im = clamp_word((ar * bi + ai * br) >>> FRAC_BITS, sat);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = ST_DIV0;
        end else begin
          r.re = clamp_word(scaled_quotient(ar * br + ai * bi, den), sat);
          r.im = clamp_word(scaled_quotient(ai * br - ar * bi, den), sat);
        end
      end
      OP_NEG: begin
        r.re = clamp_word(-ar, sat);
        r.im = clamp_word(-ai, sat);
      end
      OP_PASS: begin
        r.re = it.a_re;
        r.im = it.a_im;
      end
      OP_EQ: r.cmp = (ar == br) && (ai == bi);
      OP_NE: r.cmp = (ar != br) || (ai != bi);
      OP_MAG: begin
        den = ar * ar + ai * ai;
        r.re = clamp_word(wide_t'(int_sqrt(den[63:0])), sat);
      end
      default: ;
    endcase
    if (sat && r.status == ST_OK) r.status = ST_SAT;
    return r;
  endfunction

  function automatic word_t random_word();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return word_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      4: return word_t'($signed($urandom_range(0, 32'h7ff_ffff)) - 32'sh3ff_ffff);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic add_item(input logic [3:0] code, input word_t ar, input word_t ai,
                          input word_t br, input word_t bi, input bit drain);
    pending_items.push_back('{code, ar, ai, br, bi, drain});
  endtask

  // In a burst phase both sides run without idling.
  function automatic bit burst_phase();
    return ((items_sent / 150) % 3) == 1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: presents queued items with a random gap after each one outside burst phases.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      items_sent <= 0;
      op <= OP_ADD;
      a_re <= '0;
      a_im <= '0;
      b_re <= '0;
      b_im <= '0;
    end else if (in_valid && in_stall) begin
      // Hold the payload while stalled.
    end else begin
      if (in_valid) begin
        expected_results.push_back(compute_result('{op, a_re, a_im, b_re, b_im, 1'b0}));
        op_count[op] <= op_count[op] + 1;
        items_sent <= items_sent + 1;
      end
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0 &&
                   !(pending_items[0].drain &&
                     (in_valid || items_sent != results_seen))) begin
        op <= pending_items[0].op;
        a_re <= pending_items[0].a_re;
        a_im <= pending_items[0].a_im;
        b_re <= pending_items[0].b_re;
        b_im <= pending_items[0].b_im;
        void'(pending_items.pop_front());
        in_valid <= 1'b1;
        gap_left <= burst_phase() ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: takes results under random stalls outside burst phases and checks each one.
  always @(posedge clk) begin
    alu_result_t want;
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      results_seen <= 0;
    end else if (out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: re=%h im=%h", res_re, res_im);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (res_re !== want.re) begin
          $error("res_re expected %h actual %h", want.re, res_re);
          errors++;
        end
        if (res_im !== want.im) begin
          $error("res_im expected %h actual %h", want.im, res_im);
          errors++;
        end
        if (cmp_true !== want.cmp) begin
          $error("cmp_true expected %b actual %b", want.cmp, cmp_true);
          errors++;
        end
        if (status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, status);
          errors++;
        end
      end
      n = burst_phase() ? 0 : $urandom_range(0, 9);
      stall_left <= n;
      out_stall <= (n != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    operands_t it;
    errors = 0;
    for (int i = 0; i < 16; i++) op_count[i] = 0;
    rst = 1'b1;

    // Directed: extremes, every operation and the documented corner cases.
    add_item(OP_ADD, WORD_MAX, WORD_MIN, 32'sh1, -32'sh1, 1'b0);
    add_item(OP_ADD, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 1'b0);
    add_item(OP_SUB, 32'sh0003_0000, '0, 32'sh0001_8000, 32'sh0002_0000, 1'b0);
    add_item(OP_SUB, WORD_MIN, WORD_MAX, 32'sh1, -32'sh1, 1'b0);
    add_item(OP_MUL, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000, -32'sh0001_0000, 1'b0);
    add_item(OP_MUL, -32'sh1, 32'sh1, 32'sh1, 32'sh1, 1'b0);
    add_item(OP_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, 1'b0);
    add_item(OP_DIV, 32'sh0001_0000, '0, 32'sh0003_0000, 32'sh0004_0000, 1'b0);
    add_item(OP_DIV, -32'sh0007_0000, 32'sh0001_0000, 32'sh0002_0000, '0, 1'b0);
    add_item(OP_DIV, WORD_MAX, WORD_MAX, '0, 32'sh1, 1'b0);
    add_item(OP_DIV, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0);
    add_item(OP_DIV, 32'sh0005_0000, 32'sh0001_0000, '0, '0, 1'b0);
    add_item(OP_NEG, WORD_MIN, WORD_MAX, '0, '0, 1'b0);
    add_item(OP_NEG, 32'sh0001_0000, '0, '0, '0, 1'b0);
    add_item(OP_PASS, WORD_MIN, WORD_MAX, 32'sh5, 32'sh6, 1'b0);
    add_item(OP_EQ, 32'sh1234, -32'sh5, 32'sh1234, -32'sh5, 1'b0);
    add_item(OP_EQ, 32'sh1234, -32'sh5, 32'sh1234, -32'sh4, 1'b0);
    add_item(OP_NE, 32'sh1234, -32'sh5, 32'sh1234, -32'sh5, 1'b0);
    add_item(OP_NE, '0, '0, '0, 32'sh1, 1'b0);
    add_item(OP_MAG, 32'sh0003_0000, -32'sh0004_0000, '0, '0, 1'b0);
    add_item(OP_MAG, WORD_MIN, WORD_MIN, '0, '0, 1'b0);
    add_item(OP_MAG, '0, '0, '0, '0, 1'b0);
    add_item(4'd9, 32'sh1, 32'sh2, 32'sh3, 32'sh4, 1'b0);
    add_item(4'd15, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 1'b1);

    for (int i = 0; i < 1430; i++) begin
      it.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, 8));
      it.a_re = random_word();
      it.a_im = random_word();
      it.b_re = random_word();
      it.b_im = random_word();
      if (it.op == OP_EQ || it.op == OP_NE) begin
        if ($urandom_range(0, 1)) begin
          it.b_re = it.a_re;
          it.b_im = ($urandom_range(0, 2) == 0) ? word_t'($urandom) : it.a_im;
        end
      end
      if (it.op == OP_DIV && $urandom_range(0, 15) == 0) begin
        it.b_re = '0;
        it.b_im = '0;
      end
      it.drain = (i % 500 == 250);
      pending_items.push_back(it);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (60) @(posedge clk);
    $display("Checked %0d items over %0d results; add/sub/mul/div %0d/%0d/%0d/%0d,",
             items_sent, results_seen, op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("neg/pass/eq/ne/mag %0d/%0d/%0d/%0d/%0d, with random gaps and stalls.",
             op_count[4], op_count[5], op_count[6], op_count[7], op_count[8]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("complex_arithmetic_unit test passed");
    end else begin
      $display("complex_arithmetic_unit test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("complex_arithmetic_unit test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/cau_pkg.sv
src/complex_arithmetic_unit.sv
tb/complex_arithmetic_unit_tb.sv
